### sv/bbfa_pkg.sv
// ----------------------------------------------------------------------------
// bbfa_pkg
// shared types and constants of the best-fit block allocator
// ----------------------------------------------------------------------------
package bbfa_pkg;

    localparam int BLOCK_BYTES_W   = 17;
    localparam int BLOCKS_IN_USE_W = 11;
    localparam int CFG_INDEX_W     = 4;
    localparam int CFG_DATA_W      = 32;
    localparam int DIVIDEND_W      = 32;

    localparam logic [BLOCK_BYTES_W-1:0]   BLOCK_BYTES_RESET   = 17'd256;
    localparam logic [BLOCK_BYTES_W-1:0]   BLOCK_BYTES_MAX     = 17'd65536;
    localparam logic [BLOCKS_IN_USE_W-1:0] BLOCKS_IN_USE_RESET = 11'd1024;

    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BYTES   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCKS_IN_USE = 4'd1;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] byte_count;
        logic [31:0] free_offset;
    } req_t;

    typedef struct packed {
        logic [31:0] alloc_offset;
        logic        alloc_failed;
    } rsp_t;

endpackage

### sv/bbfa_div.sv
// ----------------------------------------------------------------------------
// bbfa_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bbfa_div
    import bbfa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_W-1:0]    dividend,
    input  logic [BLOCK_BYTES_W-1:0] divisor,
    output logic                     done,
    output logic [DIVIDEND_W-1:0]    quotient,
    output logic [BLOCK_BYTES_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0]    quo_reg, quo_next;
    logic [BLOCK_BYTES_W-1:0] rem_reg, rem_next;
    logic [BLOCK_BYTES_W:0]   shifted;
    logic [BLOCK_BYTES_W:0]   diff;
    logic                     fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = shifted - {1'b0, divisor};
        fits      = shifted >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[BLOCK_BYTES_W-1:0] : shifted[BLOCK_BYTES_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### sv/bitmap_best_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_best_fit_block_allocator_core
// best-fit allocator over a free-block bitmap held in a word memory
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap memory to all free, one word per
// cycle, with req_ready low. Each request yields one response. Sizes and
// offsets go through a shared one-bit-per-cycle divider. An allocate then
// scans the map one block per cycle, with a memory read step before each
// word, stopping early on an exact fit, and marks the chosen run by a
// read-modify-write sweep over every map word. A free divides the offset and
// the byte count and then sweeps the map in the same way; a clear only sweeps.
// There is a single bitmap memory port and a single serial divider, and a
// new request is taken only in the idle state.
// ----------------------------------------------------------------------------
module bitmap_best_fit_block_allocator_core
    import bbfa_pkg::*;
#(
    parameter int MAX_BLOCKS    = 1024,
    parameter int MAP_WORD_BITS = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  req_t                   req,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output rsp_t                   rsp,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int IDX_W     = $clog2(MAX_BLOCKS + 1);
    localparam int SPAN_W    = $clog2(MAP_WORDS * MAP_WORD_BITS + 1);
    localparam int NEED_W    = DIVIDEND_W + 1;
    localparam int PROD_W    = BLOCK_BYTES_W + IDX_W;

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DIV_OFFS = 4'd2;
    localparam logic [3:0] S_DIV_CNT  = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_BIT = 4'd5;
    localparam logic [3:0] S_RANGE_RD = 4'd6;
    localparam logic [3:0] S_RANGE_WR = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;

    logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [MAP_WORD_BITS-1:0] rdata_reg;

    logic [3:0]                 state_reg, state_next;
    logic [BLOCK_BYTES_W-1:0]   block_bytes_reg, block_bytes_next;
    logic [BLOCKS_IN_USE_W-1:0] blocks_in_use_reg, blocks_in_use_next;
    logic [1:0]                 func_reg, func_next;
    logic [31:0]                count_reg, count_next;
    logic [31:0]                first_reg, first_next;
    logic [NEED_W-1:0]          need_reg, need_next;
    logic [WADDR_W-1:0]         w_reg, w_next;
    logic [BIT_W-1:0]           b_reg, b_next;
    logic [IDX_W-1:0]           i_reg, i_next;
    logic [SPAN_W-1:0]          wbase_reg, wbase_next;
    logic                       in_run_reg, in_run_next;
    logic [IDX_W-1:0]           run_len_reg, run_len_next;
    logic [IDX_W-1:0]           run_start_reg, run_start_next;
    logic                       found_reg, found_next;
    logic [IDX_W-1:0]           best_len_reg, best_len_next;
    logic [IDX_W-1:0]           win_start_reg, win_start_next;
    logic [IDX_W-1:0]           lo_reg, lo_next;
    logic [IDX_W-1:0]           hi_reg, hi_next;
    logic                       set_mode_reg, set_mode_next;
    logic                       res_ok_reg, res_ok_next;
    logic                       res_failed_reg, res_failed_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    rsp_t                       rsp_reg, rsp_next;

    logic [BLOCK_BYTES_W-1:0] eff_bb;
    logic [IDX_W-1:0]         eff_n;
    logic [31:0]              biu_wide;

    logic                     div_start;
    logic                     div_done;
    logic [DIVIDEND_W-1:0]    div_dividend;
    logic [DIVIDEND_W-1:0]    div_quo;
    logic [BLOCK_BYTES_W-1:0] div_rem;
    logic [NEED_W-1:0]        need_calc;
    logic [NEED_W:0]          end_calc;

    logic                     mem_re, mem_we;
    logic [MAP_WORD_BITS-1:0] mem_wdata;
    logic [MAP_WORD_BITS-1:0] range_mask;
    logic [SPAN_W-1:0]        bit_idx;

    logic                     cur_free;
    logic                     last_bit;
    logic                     eval_en;
    logic [IDX_W-1:0]         eval_len, eval_start;
    logic                     fits, exact;
    logic [PROD_W-1:0]        prod;

    always_comb
    begin
        if (block_bytes_reg == '0)
        begin
            eff_bb = BLOCK_BYTES_W'(1);
        end
        else if (block_bytes_reg > BLOCK_BYTES_MAX)
        begin
            eff_bb = BLOCK_BYTES_MAX;
        end
        else
        begin
            eff_bb = block_bytes_reg;
        end
        biu_wide = 32'(blocks_in_use_reg);
        eff_n = (biu_wide > 32'(MAX_BLOCKS)) ? IDX_W'(MAX_BLOCKS) : IDX_W'(biu_wide);
    end

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        blocks_in_use_next = blocks_in_use_reg;
        block_bytes_next   = block_bytes_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BLOCK_BYTES:   block_bytes_next   = cfg_data[BLOCK_BYTES_W-1:0];
                CFG_BLOCKS_IN_USE: blocks_in_use_next = cfg_data[BLOCKS_IN_USE_W-1:0];
                default:           ;
            endcase
        end
    end

    // divider
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            div_dividend = (req.func == FUNC_FREE) ? req.free_offset : req.byte_count;
        end
        else
        begin
            div_dividend = count_reg;
        end
        need_calc = NEED_W'(div_quo) + NEED_W'(div_rem != '0);
        end_calc  = (NEED_W + 1)'(first_reg) + (NEED_W + 1)'(need_reg);
    end

    bbfa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (eff_bb),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // range mask for the word under update
    always_comb
    begin
        range_mask = '0;
        bit_idx    = '0;
        for (int k = 0; k < MAP_WORD_BITS; k++)
        begin
            bit_idx       = wbase_reg + SPAN_W'(k);
            range_mask[k] = (bit_idx >= SPAN_W'(lo_reg)) && (bit_idx < SPAN_W'(hi_reg));
        end
        mem_wdata = set_mode_reg ? (rdata_reg | range_mask) : (rdata_reg & ~range_mask);
        if (state_reg == S_INIT)
        begin
            mem_wdata = '1;
        end
    end

    // run tracking for the bit under scan
    always_comb
    begin
        cur_free   = rdata_reg[b_reg];
        last_bit   = (i_reg + 1'b1) == eff_n;
        eval_en    = 1'b0;
        eval_len   = run_len_reg;
        eval_start = run_start_reg;
        if (cur_free)
        begin
            eval_len   = in_run_reg ? run_len_reg + 1'b1 : IDX_W'(1);
            eval_start = in_run_reg ? run_start_reg : i_reg;
            eval_en    = last_bit;
        end
        else
        begin
            eval_en = in_run_reg;
        end
        fits  = eval_en && (NEED_W'(eval_len) >= need_reg)
                && (!found_reg || (eval_len < best_len_reg));
        exact = fits && (NEED_W'(eval_len) == need_reg);
    end

    assign prod = PROD_W'(eff_bb) * PROD_W'(win_start_reg);

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        count_next      = count_reg;
        first_next      = first_reg;
        need_next       = need_reg;
        w_next          = w_reg;
        b_next          = b_reg;
        i_next          = i_reg;
        wbase_next      = wbase_reg;
        in_run_next     = in_run_reg;
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        found_next      = found_reg;
        best_len_next   = best_len_reg;
        win_start_next  = win_start_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        set_mode_next   = set_mode_reg;
        res_ok_next     = res_ok_reg;
        res_failed_next = res_failed_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        div_start       = 1'b0;
        mem_re          = 1'b0;
        mem_we          = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                w_next = w_reg + 1'b1;
                if (w_reg == WADDR_W'(MAP_WORDS - 1))
                begin
                    w_next     = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next       = req.func;
                    count_next      = req.byte_count;
                    res_ok_next     = 1'b0;
                    res_failed_next = 1'b0;
                    w_next          = '0;
                    wbase_next      = '0;
                    case (req.func)
                        FUNC_ALLOC:
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV_CNT;
                        end
                        FUNC_FREE:
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV_OFFS;
                        end
                        FUNC_CLEAR:
                        begin
                            lo_next       = '0;
                            hi_next       = eff_n;
                            set_mode_next = 1'b1;
                            state_next    = S_RANGE_RD;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_DIV_OFFS:
            begin
                if (div_done)
                begin
                    first_next = div_quo;
                    div_start  = 1'b1;
                    state_next = S_DIV_CNT;
                end
            end
            S_DIV_CNT:
            begin
                if (div_done)
                begin
                    need_next = need_calc;
                    if (func_reg == FUNC_ALLOC)
                    begin
                        if ((need_calc == '0) || (need_calc > NEED_W'(eff_n)))
                        begin
                            res_failed_next = 1'b1;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            i_next      = '0;
                            b_next      = '0;
                            in_run_next = 1'b0;
                            found_next  = 1'b0;
                            state_next  = S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        set_mode_next = 1'b1;
                        state_next    = S_RANGE_RD;
                        if (NEED_W'(first_reg) >= NEED_W'(eff_n))
                        begin
                            lo_next = eff_n;
                        end
                        else
                        begin
                            lo_next = IDX_W'(first_reg);
                        end
                    end
                end
            end
            S_SCAN_RD:
            begin
                mem_re     = 1'b1;
                b_next     = '0;
                state_next = S_SCAN_BIT;
            end
            S_SCAN_BIT:
            begin
                i_next = i_reg + 1'b1;
                b_next = b_reg + 1'b1;
                if (cur_free)
                begin
                    in_run_next    = 1'b1;
                    run_len_next   = eval_len;
                    run_start_next = eval_start;
                end
                else
                begin
                    in_run_next = 1'b0;
                end
                if (fits)
                begin
                    found_next     = 1'b1;
                    best_len_next  = eval_len;
                    win_start_next = eval_start;
                end
                if (exact || (last_bit && (fits || found_reg)))
                begin
                    lo_next       = fits ? eval_start : win_start_reg;
                    hi_next       = (fits ? eval_start : win_start_reg)
                                    + need_reg[IDX_W-1:0];
                    set_mode_next = 1'b0;
                    res_ok_next   = 1'b1;
                    w_next        = '0;
                    wbase_next    = '0;
                    state_next    = S_RANGE_RD;
                end
                else if (last_bit)
                begin
                    res_failed_next = 1'b1;
                    state_next      = S_FIN;
                end
                else if (b_reg == BIT_W'(MAP_WORD_BITS - 1))
                begin
                    w_next     = w_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_RANGE_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_RANGE_WR;
                if ((func_reg == FUNC_FREE) && set_mode_reg && (w_reg == '0)
                    && (wbase_reg == '0))
                begin
                    if (end_calc > (NEED_W + 1)'(eff_n))
                    begin
                        hi_next = eff_n;
                    end
                    else
                    begin
                        hi_next = IDX_W'(end_calc);
                    end
                    if (end_calc <= (NEED_W + 1)'(lo_reg))
                    begin
                        hi_next = lo_reg;
                    end
                end
            end
            S_RANGE_WR:
            begin
                mem_we     = 1'b1;
                w_next     = w_reg + 1'b1;
                wbase_next = wbase_reg + SPAN_W'(MAP_WORD_BITS);
                state_next = S_RANGE_RD;
                if (w_reg == WADDR_W'(MAP_WORDS - 1))
                begin
                    w_next     = '0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.alloc_failed = res_failed_reg;
                    rsp_next.alloc_offset = res_ok_reg ? 32'(prod) : 32'd0;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // bitmap memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[w_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= map_mem[w_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_INIT;
            block_bytes_reg   <= BLOCK_BYTES_RESET;
            blocks_in_use_reg <= BLOCKS_IN_USE_RESET;
            w_reg             <= '0;
            rsp_valid_reg     <= 1'b0;
            found_reg         <= 1'b0;
            in_run_reg        <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            block_bytes_reg   <= block_bytes_next;
            blocks_in_use_reg <= blocks_in_use_next;
            w_reg             <= w_next;
            rsp_valid_reg     <= rsp_valid_next;
            found_reg         <= found_next;
            in_run_reg        <= in_run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        count_reg      <= count_next;
        first_reg      <= first_next;
        need_reg       <= need_next;
        b_reg          <= b_next;
        i_reg          <= i_next;
        wbase_reg      <= wbase_next;
        run_len_reg    <= run_len_next;
        run_start_reg  <= run_start_next;
        best_len_reg   <= best_len_next;
        win_start_reg  <= win_start_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        set_mode_reg   <= set_mode_next;
        res_ok_reg     <= res_ok_next;
        res_failed_reg <= res_failed_next;
        rsp_reg        <= rsp_next;
    end

    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == S_FIN)
        else $error("response raised outside the finish step");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.alloc_failed |-> rsp.alloc_offset == 32'd0)
        else $error("failed allocation with nonzero offset");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN_BIT |-> i_reg < eff_n)
        else $error("scan index past managed blocks");

    a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN_BIT && found_reg |-> NEED_W'(best_len_reg) >= need_reg)
        else $error("chosen run shorter than request");

endmodule
